// File: rtl/core/expiry_min_heap_macros.svh
// Assertion macros for the expiry min-heap block
`ifndef EXPIRY_MIN_HEAP_MACROS_SVH
`define EXPIRY_MIN_HEAP_MACROS_SVH
`ifndef SYNTHESIS
`define EMH_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define EMH_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define EMH_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define EMH_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/core/emh_pkg.sv
// Types and constants shared by the expiry min-heap files
package emh_pkg;
  localparam int KeyW = 16;
  localparam int TimeW = 32;
  localparam int EntW = KeyW + TimeW;
  localparam int CntOutW = 9;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_PEEK   = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [KeyW-1:0]  key;
    logic [TimeW-1:0] tim;
  } entry_t;

  // input beat
  typedef struct packed {
    action_t          action;
    logic [KeyW-1:0]  key_handle;
    logic [TimeW-1:0] expire_time;
  } heap_req_t;

  // result beat
  typedef struct packed {
    status_t             status;
    logic [KeyW-1:0]     min_key_handle;
    logic [TimeW-1:0]    min_expire_time;
    logic [CntOutW-1:0]  entry_count;
  } heap_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RD_ROOT, S_ROOT, S_UP_RD, S_UP_CMP,
    S_DN_RD_LAST, S_DN_LAST, S_DN_RD_L, S_DN_RD_R, S_DN_CMP, S_OUT
  } fsm_t;
endpackage

// File: rtl/core/emh_if.sv
// Valid/ready channel carrying one beat of payload
interface emh_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/emh_mem.sv
// Heap entry memory: one write port, one registered read port
module emh_mem #(
  parameter int Depth = 256,
  parameter int AddrW = 8
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AddrW-1:0]   waddr,
  input  emh_pkg::entry_t    wdata,
  input  logic [AddrW-1:0]   raddr,
  output emh_pkg::entry_t    rdata
);
  import emh_pkg::*;
  entry_t mem [Depth];

  // write and read, read data registered
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/core/expiry_min_heap.sv
// Top level of the expiry min-heap priority queue
//   channel | dir | fields
//   in_     | in  | action, key_handle, expire_time
//   out_    | out | status, min_key_handle, min_expire_time, entry_count
// One item at a time. Peek reads the root; insert puts the new entry at the end
// and moves it up past each parent with a later expire time, at most to the
// root; remove takes the root, moves the last entry there and sifts it down.
// The single memory read port sets the pace: one read per cycle.
// Reset clears the count and the sequencer; memory holds no reset state.
// A held result stalls the sequencer in its last step only; input waits for it.
module expiry_min_heap #(
  parameter int HEAP_DEPTH = 256
) (
  input logic clk,
  input logic rst_n,
  emh_if.sink   in_ch,
  emh_if.source out_ch
);
  import emh_pkg::*;
  `include "expiry_min_heap_macros.svh"

  localparam int AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int CW = $clog2(HEAP_DEPTH + 1);
  localparam int PW = AW + 2;

  fsm_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [PW-1:0] pick_r, pick_nxt;
  entry_t cur_r, cur_nxt, best_r, best_nxt, ins_r, ins_nxt;
  action_t act_r, act_nxt;
  logic ovalid_r, ovalid_nxt;
  status_t ost_r, ost_nxt;
  entry_t omin_r, omin_nxt;
  status_t ostat_r, ostat_nxt;
  entry_t oent_r, oent_nxt;
  logic [CntOutW-1:0] ocnt_r, ocnt_nxt;

  logic we;
  logic [AW-1:0] waddr, raddr;
  entry_t wdata, rdata;

  emh_mem #(.Depth(HEAP_DEPTH), .AddrW(AW)) u_mem (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  logic [PW-1:0] par, lch, rch;
  assign par = (pos_r - PW'(1)) >> 1;
  assign lch = {pos_r[PW-2:0], 1'b1};
  assign rch = lch + PW'(1);

  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = ovalid_r;
  assign out_ch.data.status = ostat_r;
  assign out_ch.data.min_key_handle = oent_r.key;
  assign out_ch.data.min_expire_time = oent_r.tim;
  assign out_ch.data.entry_count = ocnt_r;

  // hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      ovalid_r <= ovalid_nxt;
    end
    pos_r <= pos_nxt; pick_r <= pick_nxt; cur_r <= cur_nxt; best_r <= best_nxt;
    ins_r <= ins_nxt; act_r <= act_nxt; ost_r <= ost_nxt; omin_r <= omin_nxt;
    ostat_r <= ostat_nxt; oent_r <= oent_nxt; ocnt_r <= ocnt_nxt;
  end

  // sequence the sift steps
  always_comb begin
    state_nxt = state_r; cnt_nxt = cnt_r; pos_nxt = pos_r; pick_nxt = pick_r;
    cur_nxt = cur_r; best_nxt = best_r; ins_nxt = ins_r; act_nxt = act_r;
    ovalid_nxt = ovalid_r; ost_nxt = ost_r; omin_nxt = omin_r;
    ostat_nxt = ostat_r; oent_nxt = oent_r; ocnt_nxt = ocnt_r;
    we = 1'b0; waddr = '0; wdata = cur_r; raddr = '0;
    if (ovalid_r && out_ch.ready) ovalid_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid && in_ch.ready) begin
          act_nxt = action_t'(in_ch.data.action);
          ins_nxt = '{key: in_ch.data.key_handle, tim: in_ch.data.expire_time};
          ost_nxt = ST_OK; omin_nxt = '0;
          case (action_t'(in_ch.data.action))
            ACT_INSERT: begin
              if (cnt_r >= CW'(HEAP_DEPTH)) begin
                ost_nxt = ST_FULL; state_nxt = S_OUT;
              end else begin
                pos_nxt = PW'(cnt_r); cur_nxt = ins_nxt;
                cnt_nxt = cnt_r + CW'(1); state_nxt = S_UP_RD;
              end
            end
            ACT_REMOVE, ACT_PEEK: begin
              if (cnt_r == '0) begin
                ost_nxt = ST_EMPTY; state_nxt = S_OUT;
              end else state_nxt = S_RD_ROOT;
            end
            default: state_nxt = S_OUT;
          endcase
        end
      end
      S_RD_ROOT: begin
        raddr = '0; state_nxt = S_ROOT;
      end
      S_ROOT: begin
        omin_nxt = rdata;
        if (act_r == ACT_REMOVE) begin
          cnt_nxt = cnt_r - CW'(1);
          state_nxt = (cnt_r == CW'(1)) ? S_OUT : S_DN_RD_LAST;
        end else state_nxt = S_OUT;
      end
      S_UP_RD: begin
        if (pos_r == '0) begin
          we = 1'b1; waddr = AW'(pos_r); state_nxt = S_OUT;
        end else begin
          raddr = AW'(par); state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (cur_r.tim < rdata.tim) begin
          we = 1'b1; waddr = AW'(pos_r); wdata = rdata;
          pos_nxt = par; state_nxt = S_UP_RD;
        end else begin
          we = 1'b1; waddr = AW'(pos_r); state_nxt = S_OUT;
        end
      end
      S_DN_RD_LAST: begin
        raddr = AW'(cnt_r); pos_nxt = '0; state_nxt = S_DN_LAST;
      end
      S_DN_LAST: begin
        cur_nxt = rdata; state_nxt = S_DN_RD_L;
      end
      S_DN_RD_L: begin
        best_nxt = cur_r; pick_nxt = pos_r;
        if (lch < PW'(cnt_r)) begin
          raddr = AW'(lch); state_nxt = S_DN_RD_R;
        end else begin
          we = 1'b1; waddr = AW'(pos_r); state_nxt = S_OUT;
        end
      end
      S_DN_RD_R: begin
        if (!(cur_r.tim < rdata.tim)) begin
          best_nxt = rdata; pick_nxt = lch;
        end
        if (rch < PW'(cnt_r)) begin
          raddr = AW'(rch); state_nxt = S_DN_CMP;
        end else state_nxt = S_DN_CMP;
      end
      S_DN_CMP: begin
        if ((rch < PW'(cnt_r)) && !(best_r.tim < rdata.tim)) begin
          best_nxt = rdata; pick_nxt = rch;
        end
        if (pick_nxt == pos_r) begin
          we = 1'b1; waddr = AW'(pos_r); state_nxt = S_OUT;
        end else begin
          we = 1'b1; waddr = AW'(pos_r); wdata = best_nxt;
          pos_nxt = pick_nxt; state_nxt = S_DN_RD_L;
        end
      end
      S_OUT: begin
        // load the result register once it is free or being drained
        if (!ovalid_r || out_ch.ready) begin
          ovalid_nxt = 1'b1; ostat_nxt = ost_r; oent_nxt = omin_r;
          ocnt_nxt = CntOutW'(cnt_r); state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  `EMH_ASSERT_IMP(a_cnt_range, clk, rst_n, 1'b1, cnt_r <= CW'(HEAP_DEPTH))
  `EMH_ASSERT_IMP(a_no_accept_busy, clk, rst_n, state_r != S_IDLE, !in_ch.ready)
  `EMH_ASSERT_NXT(a_out_hold, clk, rst_n, out_ch.valid && !out_ch.ready, out_ch.valid)
  `EMH_ASSERT_IMP(a_wr_in_range, clk, rst_n, we, PW'(waddr) < PW'(cnt_r))
endmodule
